// File: rtl/sacl_pkg.sv
`timescale 1ns / 1ps
package sacl_pkg;

	localparam int DEF_NUM_SETS    = 64;
	localparam int DEF_NUM_WAYS    = 4;
	localparam int DEF_BLOCK_BYTES = 16;

	localparam int WORD_W  = 32;
	localparam int STAMP_W = 32;
	localparam int KIND_W  = 2;

	// transaction kinds
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FILL  = 2'd2;

	localparam logic [STAMP_W-1:0] STAMP_RESET = 32'd1;

	// floor(log2(v)), elaboration time only
	function automatic int floor_log2(input int v);
		int n;
		int x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n = n + 1;
		end
		return n;
	endfunction

endpackage

// File: rtl/set_assoc_cache_lru_core.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// request  | in        | in_valid / in_ready  | kind, address, write_data
// response | out       | out_valid / out_ready| hit, read_data, four hit/miss counters
//
// Each transaction first reads the set's tag/stamp row and the addressed
// word row from the two synchronous RAMs, then compares, picks the victim
// and writes back the rows that change (none on a read miss).
// After reset a clearing pass over all 2^(index bits + word bits) word rows
// (256 by default) clears both RAMs (stamps to STAMP_RESET); in_ready stays low meanwhile.
// A new request is taken while a response waits; the compare cycle holds
// until the response register is free.
module set_assoc_cache_lru_core #(
	parameter int NUM_SETS    = sacl_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS    = sacl_pkg::DEF_NUM_WAYS,
	parameter int BLOCK_BYTES = sacl_pkg::DEF_BLOCK_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sacl_pkg::KIND_W-1:0]         kind,
	input  logic [31:0]                         address,
	input  logic [sacl_pkg::WORD_W-1:0]         write_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [sacl_pkg::WORD_W-1:0]         read_data,
	output logic [31:0]                         read_hit_count,
	output logic [31:0]                         read_miss_count,
	output logic [31:0]                         write_hit_count,
	output logic [31:0]                         write_miss_count
);

	// address split
	localparam int OB      = sacl_pkg::floor_log2(BLOCK_BYTES);
	localparam int IB      = sacl_pkg::floor_log2(NUM_SETS);
	localparam int WB      = OB - 2;
	localparam int TAG_W   = 32 - OB - IB;
	localparam int SET_AW  = (IB > 0) ? IB : 1;
	localparam int ROW_AW  = (IB + WB > 0) ? IB + WB : 1;
	localparam int SETS_A  = 1 << IB;
	localparam int ROWS    = 1 << (IB + WB);
	localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int P2      = 1 << $clog2(NUM_WAYS);
	localparam logic [31:0] SET_MASK = 32'((64'd1 << IB) - 64'd1);
	localparam logic [31:0] ROW_MASK = 32'((64'd1 << (IB + WB)) - 64'd1);

	typedef struct packed {
		logic                          valid;
		logic [TAG_W-1:0]              tag;
		logic [sacl_pkg::STAMP_W-1:0]  stamp;
	} meta_t;

	typedef meta_t [NUM_WAYS-1:0]                        meta_row_t;
	typedef logic [NUM_WAYS-1:0][sacl_pkg::WORD_W-1:0]   word_row_t;

	typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_LOOK} state_t;

	state_t                         state_q;
	logic [ROW_AW-1:0]              clr_q;
	logic [sacl_pkg::STAMP_W-1:0]   stamp_q;
	logic [31:0]                    rd_hit_q, rd_miss_q, wr_hit_q, wr_miss_q;
	logic                           out_valid_q;
	logic                           hit_q;
	logic [sacl_pkg::WORD_W-1:0]    rdata_q;

	// captured request
	logic [sacl_pkg::KIND_W-1:0]    kind_s1;
	logic [TAG_W-1:0]               tag_s1;
	logic [SET_AW-1:0]              set_s1;
	logic [ROW_AW-1:0]              row_s1;
	logic [sacl_pkg::WORD_W-1:0]    data_s1;

	// RAMs: one tag/stamp row per set, one word row per (set, word)
	meta_row_t                      meta_mem [0:SETS_A-1];
	word_row_t                      word_mem [0:ROWS-1];
	meta_row_t                      meta_rd_q;
	word_row_t                      word_rd_q;

	logic                           accept;
	logic                           out_free;
	logic                           finish;
	logic [SET_AW-1:0]              set_in;
	logic [ROW_AW-1:0]              row_in;

	logic                           found;
	logic [WAY_W-1:0]               hit_way;
	logic [WAY_W-1:0]               victim;
	logic [WAY_W-1:0]               tgt_way;
	logic                           is_read, do_write, touch;
	logic                           rd_hit, wr_hit, wr_miss;
	logic [sacl_pkg::STAMP_W-1:0]   nst [1:2*P2-1];
	logic [WAY_W-1:0]               nwy [1:2*P2-1];

	meta_row_t                      meta_new;
	word_row_t                      word_new;
	logic                           meta_we, word_we;
	logic [SET_AW-1:0]              meta_wa;
	logic [ROW_AW-1:0]              word_wa;
	meta_row_t                      meta_wd;
	word_row_t                      word_wd;
	meta_row_t                      meta_clr;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_LOOK) && out_free;

	assign set_in = SET_AW'((address >> OB) & SET_MASK);
	assign row_in = ROW_AW'((address >> 2) & ROW_MASK);

	// hit detect: lowest matching way wins
	always_comb begin
		found   = 1'b0;
		hit_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (meta_rd_q[w].valid && meta_rd_q[w].tag == tag_s1) begin
				found   = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// LRU victim: min-stamp tree, left (lower way) wins ties
	always_comb begin
		for (int i = 0; i < P2; i++) begin
			nst[P2 + i] = (i < NUM_WAYS) ? meta_rd_q[i].stamp : '1;
			nwy[P2 + i] = WAY_W'(i);
		end
		for (int n = P2 - 1; n >= 1; n--) begin
			if (nst[2*n] <= nst[2*n+1]) begin
				nst[n] = nst[2*n];
				nwy[n] = nwy[2*n];
			end else begin
				nst[n] = nst[2*n+1];
				nwy[n] = nwy[2*n+1];
			end
		end
		victim = nwy[1];
	end

	always_comb begin
		is_read  = (kind_s1 == sacl_pkg::KIND_READ);
		do_write = (kind_s1 == sacl_pkg::KIND_WRITE) || (kind_s1 == sacl_pkg::KIND_FILL);
		rd_hit   = is_read && found;
		wr_hit   = (kind_s1 == sacl_pkg::KIND_WRITE) && found;
		wr_miss  = (kind_s1 == sacl_pkg::KIND_WRITE) && !found;
		touch    = do_write || rd_hit;
		tgt_way  = (rd_hit || wr_hit) ? hit_way : victim;

		meta_new = meta_rd_q;
		word_new = word_rd_q;
		if (touch) begin
			meta_new[tgt_way].stamp = stamp_q;
		end
		if (do_write) begin
			meta_new[tgt_way].valid = 1'b1;
			meta_new[tgt_way].tag   = tag_s1;
			word_new[tgt_way]       = data_s1;
		end
	end

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			meta_clr[w].valid = 1'b0;
			meta_clr[w].tag   = '0;
			meta_clr[w].stamp = sacl_pkg::STAMP_RESET;
		end
	end

	// write port: clearing pass or write-back
	always_comb begin
		if (state_q == ST_CLR) begin
			meta_we = 1'b1;
			word_we = 1'b1;
			meta_wa = SET_AW'(clr_q >> WB);
			word_wa = clr_q;
			meta_wd = meta_clr;
			word_wd = '0;
		end else begin
			meta_we = finish && touch;
			word_we = finish && do_write;
			meta_wa = set_s1;
			word_wa = row_s1;
			meta_wd = meta_new;
			word_wd = word_new;
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (word_we) begin
			word_mem[word_wa] <= word_wd;
		end
		if (accept) begin
			meta_rd_q <= meta_mem[set_in];
			word_rd_q <= word_mem[row_in];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			tag_s1  <= TAG_W'(address >> (OB + IB));
			set_s1  <= set_in;
			row_s1  <= row_in;
			data_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			stamp_q     <= sacl_pkg::STAMP_RESET;
			rd_hit_q    <= '0;
			rd_miss_q   <= '0;
			wr_hit_q    <= '0;
			wr_miss_q   <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			rdata_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_AW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= rd_hit || wr_hit;
						rdata_q     <= rd_hit ? word_rd_q[hit_way] : '0;
						if (touch) begin
							stamp_q <= stamp_q + 1'b1;
						end
						if (rd_hit) begin
							rd_hit_q <= rd_hit_q + 1'b1;
						end
						if (is_read && !found) begin
							rd_miss_q <= rd_miss_q + 1'b1;
						end
						if (wr_hit) begin
							wr_hit_q <= wr_hit_q + 1'b1;
						end
						if (wr_miss) begin
							wr_miss_q <= wr_miss_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign read_data        = rdata_q;
	assign read_hit_count   = rd_hit_q;
	assign read_miss_count  = rd_miss_q;
	assign write_hit_count  = wr_hit_q;
	assign write_miss_count = wr_miss_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !in_ready)
		else $error("request accepted during clearing pass");

	a_resp_from_look: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_LOOK))
		else $error("response raised outside compare cycle");

	a_miss_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (rdata_q == '0))
		else $error("nonzero read data without hit");

	a_stamp_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!finish |=> $stable(stamp_q))
		else $error("stamp counter moved without a transaction");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(rdata_q) && $stable(hit_q))
		else $error("pending response overwritten");

endmodule
